// File: rtl/ccpi_pkg.sv
// Package for the constant pool indexer: widths, result codes, tag decode, shared types.
`default_nettype none
package ccpi_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int OUT_OFF_W   = 24;
    localparam int QDEPTH      = 4;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] TAG_UTF8      = 8'd1;
    localparam logic [7:0] TAG_INTEGER   = 8'd3;
    localparam logic [7:0] TAG_FLOAT     = 8'd4;
    localparam logic [7:0] TAG_LONG      = 8'd5;
    localparam logic [7:0] TAG_DOUBLE    = 8'd6;
    localparam logic [7:0] TAG_CLASS     = 8'd7;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_FIELDREF  = 8'd9;
    localparam logic [7:0] TAG_METHODREF = 8'd10;
    localparam logic [7:0] TAG_IFMETHREF = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [15:0]          slot_index;
        logic [OUT_OFF_W-1:0] byte_offset;
        logic [7:0]           entry_tag;
        logic                 is_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    typedef struct packed {
        logic       legal;
        logic       utf8;
        logic       wide;
        logic [3:0] body_len;
    } tag_info_t;

    function automatic tag_info_t decode_tag(input logic [7:0] tag);
        tag_info_t info;
        info = '{legal: 1'b1, utf8: 1'b0, wide: 1'b0, body_len: 4'd0};
        unique case (tag)
            TAG_UTF8:                        info.utf8 = 1'b1;
            TAG_INTEGER, TAG_FLOAT,
            TAG_FIELDREF, TAG_METHODREF,
            TAG_IFMETHREF, TAG_NAMETYPE:     info.body_len = 4'd4;
            TAG_LONG, TAG_DOUBLE:
            begin
                info.body_len = 4'd8;
                info.wide     = 1'b1;
            end
            TAG_CLASS, TAG_STRING:           info.body_len = 4'd2;
            default:                         info.legal = 1'b0;
        endcase
        return info;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ccpi_in_if.sv
// Byte stream channel: valid, ready and one pool byte per beat.
`default_nettype none
interface ccpi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_flag;

    modport source (output valid, output data_byte, output start_flag, input ready);
    modport sink   (input valid, input data_byte, input start_flag, output ready);
endinterface
`default_nettype wire

// File: rtl/ccpi_out_if.sv
// Result channel: valid, ready and one indexer result per beat.
`default_nettype none
interface ccpi_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic [15:0]                   slot_index;
    logic [ccpi_pkg::OUT_OFF_W-1:0] byte_offset;
    logic [7:0]                    entry_tag;
    logic                          is_last;

    modport source (output valid, output result_kind, output slot_index,
                    output byte_offset, output entry_tag, output is_last, input ready);
    modport sink   (input valid, input result_kind, input slot_index,
                    input byte_offset, input entry_tag, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/class_constant_pool_indexer.sv
// Top level of the constant pool indexer: byte parser and result queue.
//
//  channel   dir  payload                                               beat
//  stream    in   data_byte[7:0] start_flag                              one pool byte
//  report    out  result_kind[1:0] slot_index[15:0] byte_offset[23:0]    one result
//                 entry_tag[7:0] is_last
//
// One byte is parsed per cycle while stream.ready is high; a byte yields 0, 1 or 2 results in the same cycle.
// Results drain at one per beat from a 4-entry queue; stream.ready holds while the
// queue has room for two results, so with report stalled the stream stalls once
// three results are waiting.
// Reset (rst_n low) and a byte with start_flag both restart parsing at offset 0.
`default_nettype none
module class_constant_pool_indexer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ccpi_in_if.sink     stream,
    ccpi_out_if.source  report
);
    localparam int OB = ccpi_pkg::OFFSET_BITS;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

    localparam logic [2:0] PH_CNT_HI = 3'd0;
    localparam logic [2:0] PH_CNT_LO = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   total_reg, total_next;
    logic [16:0]   slot_reg, slot_next;
    logic [15:0]   skip_reg, skip_next;
    logic [OB-1:0] off_reg, off_next;
    logic [7:0]    held_reg, held_next;

    logic [2:0]    ph_e;
    logic [15:0]   total_e;
    logic [16:0]   slot_e;
    logic [15:0]   skip_e;
    logic [OB-1:0] cur;
    logic [7:0]    held_e;
    logic [7:0]    b;
    logic [15:0]   word;
    logic [15:0]   skip_dec;
    logic [16:0]   slot_plus1;
    logic          accept;
    logic          pop;
    logic          q_room;
    logic          q_not_empty;

    ccpi_pkg::tag_info_t info;
    ccpi_pkg::result_t   res0, res1, head;
    ccpi_pkg::push_t     push;
    logic [1:0]          n_res;

    assign accept         = stream.valid && stream.ready;
    assign pop            = report.valid && report.ready;
    assign stream.ready   = q_room;

    always_comb
    begin
        b = stream.data_byte;
        if (stream.start_flag)
        begin
            ph_e    = PH_CNT_HI;
            total_e = '0;
            slot_e  = 17'd1;
            skip_e  = '0;
            cur     = '0;
            held_e  = '0;
        end
        else
        begin
            ph_e    = phase_reg;
            total_e = total_reg;
            slot_e  = slot_reg;
            skip_e  = skip_reg;
            cur     = off_reg;
            held_e  = held_reg;
        end

        off_next   = (cur == OFF_MAX) ? cur : cur + OB'(1);
        word       = {held_e, b};
        skip_dec   = (skip_e != '0) ? skip_e - 16'd1 : skip_e;
        slot_plus1 = slot_e + 17'd1;
        info       = ccpi_pkg::decode_tag(b);

        phase_next = ph_e;
        total_next = total_e;
        slot_next  = slot_e;
        skip_next  = skip_e;
        held_next  = held_e;
        n_res      = 2'd0;

        res0.result_kind = ccpi_pkg::KIND_ENTRY;
        res0.slot_index  = slot_e[15:0];
        res0.byte_offset = ccpi_pkg::OUT_OFF_W'(cur);
        res0.entry_tag   = b;
        res0.is_last     = 1'b0;
        res1             = res0;
        res1.slot_index  = slot_plus1[15:0];

        unique case (ph_e)
            PH_CNT_HI:
            begin
                held_next  = b;
                phase_next = PH_CNT_LO;
            end
            PH_CNT_LO:
            begin
                total_next = word;
                slot_next  = 17'd1;
                if (17'd1 < {1'b0, word})
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next       = PH_DONE;
                    n_res            = 2'd1;
                    res0.result_kind = ccpi_pkg::KIND_DONE;
                    res0.slot_index  = 16'd1;
                    res0.byte_offset = ccpi_pkg::OUT_OFF_W'(off_next);
                    res0.entry_tag   = '0;
                end
            end
            PH_TAG:
            begin
                if (!info.legal)
                begin
                    phase_next       = PH_DONE;
                    n_res            = 2'd1;
                    res0.result_kind = ccpi_pkg::KIND_ERROR;
                end
                else
                begin
                    n_res      = 2'd1;
                    phase_next = info.utf8 ? PH_LEN_HI : PH_SKIP;
                    skip_next  = info.utf8 ? skip_e : 16'(info.body_len);
                    slot_next  = info.wide ? slot_e + 17'd2 : slot_plus1;
                    if (info.wide && (slot_plus1 < {1'b0, total_e}))
                    begin
                        n_res = 2'd2;
                    end
                end
            end
            PH_LEN_HI:
            begin
                held_next  = b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO, PH_SKIP:
            begin
                skip_next = (ph_e == PH_LEN_LO) ? word : skip_dec;
                if (skip_next != '0)
                begin
                    phase_next = PH_SKIP;
                end
                else if (slot_e < {1'b0, total_e})
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next       = PH_DONE;
                    n_res            = 2'd1;
                    res0.result_kind = ccpi_pkg::KIND_DONE;
                    res0.byte_offset = ccpi_pkg::OUT_OFF_W'(off_next);
                    res0.entry_tag   = '0;
                end
            end
            default:
            begin
                phase_next = ph_e;
            end
        endcase

        res0.is_last = (n_res == 2'd1);
        res1.is_last = 1'b1;

        push.count = accept ? n_res : 2'd0;
        push.res0  = res0;
        push.res1  = res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CNT_HI;
            total_reg <= '0;
            slot_reg  <= 17'd1;
            skip_reg  <= '0;
            off_reg   <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            total_reg <= total_next;
            slot_reg  <= slot_next;
            skip_reg  <= skip_next;
            off_reg   <= off_next;
            held_reg  <= held_next;
        end
    end

    ccpi_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .room      (q_room)
    );

    assign report.valid       = q_not_empty;
    assign report.result_kind = head.result_kind;
    assign report.slot_index  = head.slot_index;
    assign report.byte_offset = head.byte_offset;
    assign report.entry_tag   = head.entry_tag;
    assign report.is_last     = head.is_last;
endmodule
`default_nettype wire

// File: rtl/ccpi_result_queue.sv
// Small result queue: takes up to two results per cycle, hands out one per beat.
`default_nettype none
module ccpi_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ccpi_pkg::push_t   push,
    input  wire logic              pop,
    output ccpi_pkg::result_t      head,
    output logic                   not_empty,
    output logic                   room
);
    // QDEPTH is a power of two so the pointers wrap on their own
    localparam int PTR_W = $clog2(ccpi_pkg::QDEPTH);
    localparam int CNT_W = $clog2(ccpi_pkg::QDEPTH + 1);

    ccpi_pkg::result_t mem_reg [ccpi_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room         = (count_reg <= CNT_W'(ccpi_pkg::QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/ccpi_checker.sv
// Port-level checks for the constant pool indexer, bound to the top level.
`default_nettype none
module ccpi_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [1:0]                     result_kind,
    input wire logic [15:0]                    slot_index,
    input wire logic [ccpi_pkg::OUT_OFF_W-1:0] byte_offset,
    input wire logic [7:0]                     entry_tag,
    input wire logic                           is_last
);
    // a result waiting on a stalled sink keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
        $stable(slot_index) && $stable(byte_offset) && $stable(entry_tag) &&
        $stable(is_last))
        else $error("stalled result changed");

    // input backs up only when results are waiting
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result queue");

    // only a two-slot entry is followed by a second result from the same byte
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> result_kind == ccpi_pkg::KIND_ENTRY &&
        (entry_tag == ccpi_pkg::TAG_LONG || entry_tag == ccpi_pkg::TAG_DOUBLE))
        else $error("non-last result is not a long or double entry");

    // completion carries no tag and closes its byte
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == ccpi_pkg::KIND_DONE |-> entry_tag == 8'd0 && is_last)
        else $error("bad completion result");
endmodule

bind class_constant_pool_indexer ccpi_checker u_ccpi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (stream.ready),
    .out_valid   (report.valid),
    .out_ready   (report.ready),
    .result_kind (report.result_kind),
    .slot_index  (report.slot_index),
    .byte_offset (report.byte_offset),
    .entry_tag   (report.entry_tag),
    .is_last     (report.is_last)
);
`default_nettype wire
